@@ hw/rtl/uvs_pkg.sv @@
// Shared constants for the sorted unique-value store: capacity, index widths,
// request codes and result status codes. No dependencies.
`default_nettype none

package uvs_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned ST_W     = 3;

  localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE    = 3'd1;
  localparam logic [OP_W-1:0] OP_SEARCH    = 3'd2;
  localparam logic [OP_W-1:0] OP_DUMP_ASC  = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP_DESC = 3'd4;

  localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [ST_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND  = 3'd3;
  localparam logic [ST_W-1:0] ST_FOUND     = 3'd4;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd5;
  localparam logic [ST_W-1:0] ST_DUMPITEM  = 3'd6;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd7;

endpackage

`default_nettype wire

@@ hw/rtl/unique_value_set_sorted_dump_unit.sv @@
// Sorted store of distinct signed values in one memory with a registered read; uses uvs_pkg.
// A lookup reads entries in ascending order, one memory read per inspected entry; insert and
// delete then move each shifted entry with one read and one write; a dump emits one word per entry.
// One request at a time: the input stalls until the request is done, and each inspected or
// shifted entry needs its own memory access; output stalls lengthen a request.
// Reset clears the count, the state and the output valid flag; memory contents are not cleared.
`default_nettype none

module unique_value_set_sorted_dump_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [uvs_pkg::OP_W-1:0]          op_i,
  input  wire logic signed [uvs_pkg::VAL_W-1:0]  value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [uvs_pkg::ST_W-1:0]               status_o,
  output logic signed [uvs_pkg::VAL_W-1:0]       item_o,
  output logic                                   last_o
);
  import uvs_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LRD   = 4'd1;
  localparam logic [3:0] S_LCHK  = 4'd2;
  localparam logic [3:0] S_DISP  = 4'd3;
  localparam logic [3:0] S_UPRD  = 4'd4;
  localparam logic [3:0] S_UPWR  = 4'd5;
  localparam logic [3:0] S_DNRD  = 4'd6;
  localparam logic [3:0] S_DNWR  = 4'd7;
  localparam logic [3:0] S_DRD   = 4'd8;
  localparam logic [3:0] S_DEMIT = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rdata_q;
  logic                    re, we;
  logic [IDX_W-1:0]        raddr, waddr;
  logic signed [VAL_W-1:0] wdata;

  logic [3:0]              state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic [CNT_W-1:0]        j_q, j_d;
  logic                    hit_q, hit_d;
  logic [OP_W-1:0]         op_q, op_d;
  logic signed [VAL_W-1:0] value_q, value_d;
  logic [ST_W-1:0]         res_q, res_d;

  logic                    out_valid_q, out_valid_d;
  logic [ST_W-1:0]         status_q, status_d;
  logic signed [VAL_W-1:0] item_q, item_d;
  logic                    last_q, last_d;
  logic                    load;
  logic                    out_free;

  logic [CNT_W-1:0]        j_m1, j_p1, desc_idx;

  assign out_free = !out_valid_q || !out_stall_i;
  assign j_m1     = j_q - CNT_W'(1);
  assign j_p1     = j_q + CNT_W'(1);
  assign desc_idx = cnt_q - j_p1;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    j_d      = j_q;
    hit_d    = hit_q;
    op_d     = op_q;
    value_d  = value_q;
    res_d    = res_q;
    re       = 1'b0;
    we       = 1'b0;
    raddr    = idx_q[IDX_W-1:0];
    waddr    = j_q[IDX_W-1:0];
    wdata    = rdata_q;
    load     = 1'b0;
    status_d = status_q;
    item_d   = item_q;
    last_d   = last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_i;
          value_d = value_i;
          idx_d   = '0;
          j_d     = '0;
          unique case (op_i) inside
            OP_INSERT, OP_SEARCH: begin
              state_d = S_LRD;
            end
            OP_DELETE: begin
              if (cnt_q == '0) begin
                res_d   = ST_EMPTY;
                state_d = S_EMIT;
              end else begin
                state_d = S_LRD;
              end
            end
            OP_DUMP_ASC, OP_DUMP_DESC: begin
              if (cnt_q == '0) begin
                res_d   = ST_EMPTY;
                value_d = '0;
                state_d = S_EMIT;
              end else begin
                state_d = S_DRD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      // Ascending scan for the first entry not below the requested value.
      S_LRD: begin
        if (idx_q == cnt_q) begin
          hit_d   = 1'b0;
          state_d = S_DISP;
        end else begin
          re      = 1'b1;
          raddr   = idx_q[IDX_W-1:0];
          state_d = S_LCHK;
        end
      end
      S_LCHK: begin
        if (rdata_q < value_q) begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_LRD;
        end else begin
          hit_d   = (rdata_q == value_q);
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_EMIT;
        unique case (op_q)
          OP_INSERT: begin
            if (hit_q) begin
              res_d = ST_DUPLICATE;
            end else if (cnt_q == CNT_W'(CAPACITY)) begin
              res_d = ST_FULL;
            end else begin
              j_d     = cnt_q;
              state_d = S_UPRD;
            end
          end
          OP_DELETE: begin
            if (hit_q) begin
              j_d     = idx_q;
              state_d = S_DNRD;
            end else begin
              res_d = ST_NOTFOUND;
            end
          end
          default: res_d = hit_q ? ST_FOUND : ST_NOTFOUND;
        endcase
      end
      // Open a hole at the insert position by moving entries up, top first.
      S_UPRD: begin
        if (j_q == idx_q) begin
          we      = 1'b1;
          waddr   = idx_q[IDX_W-1:0];
          wdata   = value_q;
          cnt_d   = cnt_q + CNT_W'(1);
          res_d   = ST_INSERTED;
          state_d = S_EMIT;
        end else begin
          re      = 1'b1;
          raddr   = j_m1[IDX_W-1:0];
          state_d = S_UPWR;
        end
      end
      S_UPWR: begin
        we      = 1'b1;
        waddr   = j_q[IDX_W-1:0];
        j_d     = j_m1;
        state_d = S_UPRD;
      end
      // Close the gap left by a deleted entry by moving entries down.
      S_DNRD: begin
        if (j_p1 == cnt_q) begin
          cnt_d   = cnt_q - CNT_W'(1);
          res_d   = ST_DELETED;
          state_d = S_EMIT;
        end else begin
          re      = 1'b1;
          raddr   = j_p1[IDX_W-1:0];
          state_d = S_DNWR;
        end
      end
      S_DNWR: begin
        we      = 1'b1;
        waddr   = j_q[IDX_W-1:0];
        j_d     = j_p1;
        state_d = S_DNRD;
      end
      S_DRD: begin
        re      = 1'b1;
        raddr   = (op_q == OP_DUMP_ASC) ? j_q[IDX_W-1:0] : desc_idx[IDX_W-1:0];
        state_d = S_DEMIT;
      end
      S_DEMIT: begin
        if (out_free) begin
          load     = 1'b1;
          status_d = ST_DUMPITEM;
          item_d   = rdata_q;
          last_d   = (j_p1 == cnt_q);
          j_d      = j_p1;
          state_d  = (j_p1 == cnt_q) ? S_IDLE : S_DRD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load     = 1'b1;
          status_d = res_q;
          item_d   = value_q;
          last_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    j_q      <= j_d;
    hit_q    <= hit_d;
    op_q     <= op_d;
    value_q  <= value_d;
    res_q    <= res_d;
    status_q <= status_d;
    item_q   <= item_d;
    last_q   <= last_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign item_o      = item_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire
